// ===== rtl/gfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared constants and types for the gain frame parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'h8A;
  localparam logic [7:0] HDR_BYTE1 = 8'h8B;
  localparam logic [7:0] HDR_BYTE2 = 8'h1C;

  // payload offsets 1..12 are kept in the cell row
  localparam int unsigned GAIN_DEPTH = 12;
  localparam int unsigned CNT_W      = 5;

  // cell holding payload offset off (1..12) once the row is filled
  function automatic int unsigned cell_of(input int unsigned off);
    return GAIN_DEPTH - off;
  endfunction

  typedef struct packed {
    logic shift;  // push the accepted byte into the cell row
    logic fire;   // trigger byte accepted, capture the gain words
  } gfp_ctrl_t;

endpackage

// ===== rtl/gfp_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_byte_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface gfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/gfp_gain_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_gain_if
// Gain result channel, five signed 16-bit gain words.
// ----------------------------------------------------------------------------
interface gfp_gain_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] outer_kp;
  logic signed [15:0] outer_ki;
  logic signed [15:0] outer_kd;
  logic signed [15:0] inner_kp;
  logic signed [15:0] inner_kd;

  modport source (output valid, output outer_kp, output outer_ki, output outer_kd,
                  output inner_kp, output inner_kd, input ready);
  modport sink   (input valid, input outer_kp, input outer_ki, input outer_kd,
                  input inner_kp, input inner_kd, output ready);
endinterface

// ===== rtl/gfp_byte_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_byte_cell
// One byte cell of the payload row; loads its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module gfp_byte_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ===== rtl/gfp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_ctrl
// Header hunt and payload sequencing for the gain frame parser.
// ----------------------------------------------------------------------------
module gfp_ctrl import gfp_pkg::*; #(
  parameter int unsigned PAYLOAD_LEN = 28
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  logic [7:0] byte_i,
  output gfp_ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_HDR2    = 3'd2,
    PH_COLLECT = 3'd3,
    PH_TRIGGER = 3'd4
  } phase_e;

  localparam logic [CNT_W-1:0] LenInit   = CNT_W'(PAYLOAD_LEN);
  localparam logic [CNT_W-1:0] DepthLast = CNT_W'(GAIN_DEPTH);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    idx_d   = idx_q;
    if (accept_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == HDR_BYTE0) phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          phase_d = (byte_i == HDR_BYTE1) ? PH_HDR2 : PH_HUNT;
        end
        PH_HDR2: begin
          if (byte_i == HDR_BYTE2) begin
            phase_d = PH_COLLECT;
            left_d  = LenInit;
            idx_d   = '0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_COLLECT: begin
          idx_d = idx_q + CNT_W'(1);
          if (left_q <= CNT_W'(1)) begin
            left_d  = '0;
            phase_d = PH_TRIGGER;
          end else begin
            left_d = left_q - CNT_W'(1);
          end
        end
        PH_TRIGGER: begin
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // offsets 1..12 go into the cell row, offset 0 and the tail are dropped
  assign ctrl_o.shift = accept_i && (phase_q == PH_COLLECT) &&
                        (idx_q != '0) && (idx_q <= DepthLast);
  assign ctrl_o.fire  = accept_i && (phase_q == PH_TRIGGER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      idx_q   <= idx_d;
    end
  end

  a_collect_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_COLLECT) |-> (left_q != '0))
    else $error("collecting with no bytes left");

  a_trigger_after_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q == PH_TRIGGER) |-> $past(phase_q == PH_COLLECT))
    else $error("trigger phase entered outside payload");

  a_shift_fire_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.shift && ctrl_o.fire))
    else $error("shift and fire together");

endmodule

// ===== rtl/gain_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_frame_parser
// Hunts for the 8A 8B 1C header, shifts payload offsets 1..12 through a row
// of byte cells and emits five big-endian gain words on the trigger byte.
// ----------------------------------------------------------------------------
// latency: the result is valid the cycle after the trigger byte transfer
// throughput: one byte per cycle; a byte is taken whenever the output
//   register is empty or is being drained in the same cycle
// reset: async active low; clears the phase, counters and output valid,
//   the cell row holds no reset value and is refilled by every frame
module gain_frame_parser import gfp_pkg::*; #(
  parameter int unsigned PAYLOAD_LEN = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfp_byte_if.sink    rx_i,
  gfp_gain_if.source  gain_o
);

  localparam int unsigned CellKp0 = cell_of(1);
  localparam int unsigned CellKi0 = cell_of(3);
  localparam int unsigned CellKd0 = cell_of(5);
  localparam int unsigned CellIp0 = cell_of(7);
  localparam int unsigned CellId0 = cell_of(11);

  gfp_ctrl_t  ctrl;
  logic       accept;
  logic [7:0] cell_q [GAIN_DEPTH];

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] outer_kp_q, outer_ki_q, outer_kd_q, inner_kp_q, inner_kd_q;

  assign rx_i.ready = !out_valid_q || gain_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;

  gfp_ctrl #(
    .PAYLOAD_LEN(PAYLOAD_LEN)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (rx_i.rx_byte),
    .ctrl_o   (ctrl)
  );

  // new bytes enter at cell 0 and move one cell up per stored byte
  for (genvar k = 0; k < GAIN_DEPTH; k++) begin : g_cell
    logic [7:0] cell_in;
    if (k == 0) begin : g_head
      assign cell_in = rx_i.rx_byte;
    end else begin : g_link
      assign cell_in = cell_q[k-1];
    end
    gfp_byte_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl.shift),
      .byte_i  (cell_in),
      .byte_o  (cell_q[k])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (gain_o.ready) out_valid_d = 1'b0;
    if (ctrl.fire)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fire) begin
      outer_kp_q <= {cell_q[CellKp0], cell_q[CellKp0-1]};
      outer_ki_q <= {cell_q[CellKi0], cell_q[CellKi0-1]};
      outer_kd_q <= {cell_q[CellKd0], cell_q[CellKd0-1]};
      inner_kp_q <= {cell_q[CellIp0], cell_q[CellIp0-1]};
      inner_kd_q <= {cell_q[CellId0], cell_q[CellId0-1]};
    end
  end

  assign gain_o.valid    = out_valid_q;
  assign gain_o.outer_kp = outer_kp_q;
  assign gain_o.outer_ki = outer_ki_q;
  assign gain_o.outer_kd = outer_kd_q;
  assign gain_o.inner_kp = inner_kp_q;
  assign gain_o.inner_kd = inner_kd_q;

  a_result_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.fire))
    else $error("result raised without a trigger byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !gain_o.ready) |-> !ctrl.fire)
    else $error("pending result overwritten");

  a_cells_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(cell_q[0]) && $stable(cell_q[GAIN_DEPTH-1]))
    else $error("cell row moved without a transfer");

endmodule

// ===== verif/gain_frame_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_frame_parser_test
// Feeds directed and random byte streams (good frames, broken headers, line
// noise) into the parser under random idling on both channels. Gain words are
// predicted byte by byte and checked in order against every result transfer.
// ----------------------------------------------------------------------------
module gain_frame_parser_test;
  import gfp_pkg::*;

  localparam int unsigned FRAME_PAYLOAD = 28;
  localparam int unsigned TARGET_BYTES  = 1200;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef logic [7:0] payload_t [FRAME_PAYLOAD];

  typedef struct packed {
    logic signed [15:0] outer_kp;
    logic signed [15:0] outer_ki;
    logic signed [15:0] outer_kd;
    logic signed [15:0] inner_kp;
    logic signed [15:0] inner_kd;
  } gain_set_t;

  // tracks the parse position and predicts the gain words of each frame
  class gain_word_tracker;
    typedef enum logic [2:0] {
      HUNT_SYNC0, WANT_SYNC1, WANT_SYNC2, TAKE_PAYLOAD, WAIT_TRIGGER
    } parse_phase_e;

    parse_phase_e phase;
    logic [4:0]   bytes_left;
    logic [4:0]   payload_pos;
    logic [7:0]   gain_row [GAIN_DEPTH];  // payload offsets 1..12
    gain_set_t    gains_due [$];
    int unsigned  mismatches;

    function new();
      phase       = HUNT_SYNC0;
      bytes_left  = '0;
      payload_pos = '0;
      mismatches  = 0;
      foreach (gain_row[i]) gain_row[i] = '0;
    endfunction

    function logic [15:0] word_at(int unsigned off);
      return {gain_row[off - 1], gain_row[off]};
    endfunction

    function void note_rx_byte(logic [7:0] b);
      gain_set_t g;
      case (phase)
        HUNT_SYNC0: begin
          if (b == HDR_BYTE0) phase = WANT_SYNC1;
        end
        WANT_SYNC1: begin
          phase = (b == HDR_BYTE1) ? WANT_SYNC2 : HUNT_SYNC0;
        end
        WANT_SYNC2: begin
          if (b == HDR_BYTE2) begin
            phase       = TAKE_PAYLOAD;
            bytes_left  = 5'(FRAME_PAYLOAD);
            payload_pos = '0;
          end else begin
            phase = HUNT_SYNC0;
          end
        end
        TAKE_PAYLOAD: begin
          if (payload_pos >= 1 && payload_pos <= GAIN_DEPTH) gain_row[payload_pos - 1] = b;
          payload_pos = payload_pos + 5'd1;
          if (bytes_left <= 1) begin
            bytes_left = '0;
            phase      = WAIT_TRIGGER;
          end else begin
            bytes_left = bytes_left - 5'd1;
          end
        end
        WAIT_TRIGGER: begin
          // trigger byte value does not matter
          phase      = HUNT_SYNC0;
          g.outer_kp = word_at(1);
          g.outer_ki = word_at(3);
          g.outer_kd = word_at(5);
          g.inner_kp = word_at(7);
          g.inner_kd = word_at(11);
          gains_due.push_back(g);
        end
        default: phase = HUNT_SYNC0;
      endcase
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void compare_word(string field, logic signed [15:0] want, logic signed [15:0] got);
      if (want !== got) flag($sformatf("%s expected %0d got %0d", field, want, got));
    endfunction

    function void check_gain_words(gain_set_t got);
      gain_set_t want;
      if (gains_due.size() == 0) begin
        flag($sformatf("unexpected gain result %h", got));
        return;
      end
      want = gains_due.pop_front();
      compare_word("outer_kp", want.outer_kp, got.outer_kp);
      compare_word("outer_ki", want.outer_ki, got.outer_ki);
      compare_word("outer_kd", want.outer_kd, got.outer_kd);
      compare_word("inner_kp", want.inner_kp, got.inner_kp);
      compare_word("inner_kd", want.inner_kd, got.inner_kd);
    endfunction

    function int unsigned pending();
      return gains_due.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  gfp_byte_if rx_bus ();
  gfp_gain_if gain_bus ();

  gain_frame_parser #(.PAYLOAD_LEN(FRAME_PAYLOAD)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .gain_o (gain_bus)
  );

  gain_word_tracker tracker = new();

  logic [7:0]  byte_stream [$];
  int unsigned calm_left  = 0;
  int unsigned bytes_sent = 0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;

  always #5 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'h7F;
        2:       return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic payload_t gain_payload(input logic [15:0] kp, ki, kd, ikp, ikd,
                                            input logic [7:0] fill);
    payload_t p;
    foreach (p[i]) p[i] = fill;
    {p[1], p[2]}   = kp;
    {p[3], p[4]}   = ki;
    {p[5], p[6]}   = kd;
    {p[7], p[8]}   = ikp;
    {p[11], p[12]} = ikd;
    return p;
  endfunction

  function automatic void push_frame(input payload_t body, input logic [7:0] trig);
    byte_stream.push_back(HDR_BYTE0);
    byte_stream.push_back(HDR_BYTE1);
    byte_stream.push_back(HDR_BYTE2);
    foreach (body[i]) byte_stream.push_back(body[i]);
    byte_stream.push_back(trig);
  endfunction

  task automatic send_byte(input logic [7:0] b, input int unsigned gap);
    if (gap != 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (!rx_bus.ready);
    tracker.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic flush_stream();
    int unsigned gap;
    while (byte_stream.size() != 0) begin
      if (calm_left != 0) begin
        gap = 0;
        calm_left--;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(40, 120);
      end
      send_byte(byte_stream.pop_front(), gap);
    end
  endtask

  task automatic wait_results_drained();
    rx_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // result side ready, with one long hold-off on request
  initial begin : result_sink
    int unsigned idle_left;
    idle_left = 0;
    gain_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        gain_bus.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else if (idle_left != 0) begin
        gain_bus.ready <= 1'b0;
        idle_left--;
      end else begin
        gain_bus.ready <= 1'b1;
        idle_left = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && gain_bus.valid && gain_bus.ready) begin
      tracker.check_gain_words('{outer_kp: gain_bus.outer_kp, outer_ki: gain_bus.outer_ki,
                                 outer_kd: gain_bus.outer_kd, inner_kp: gain_bus.inner_kp,
                                 inner_kd: gain_bus.inner_kd});
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("gain_frame_parser regression: fail");
    $finish;
  end

  initial begin : stimulus
    payload_t    body;
    int unsigned frame_idx;
    int unsigned kind;
    int unsigned n;

    rx_bus.valid   <= 1'b0;
    rx_bus.rx_byte <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // word extremes, a header pattern inside the payload, trigger equal to sync0
    body = gain_payload(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 8'h5A);
    body[0]  = 8'hFF;
    body[9]  = 8'hAA;
    body[10] = 8'h55;
    body[14] = HDR_BYTE0;
    body[15] = HDR_BYTE1;
    body[16] = HDR_BYTE2;
    push_frame(body, HDR_BYTE0);

    // broken headers: mismatch after sync0, after sync1, and a repeated sync0
    // that must not be rechecked
    byte_stream.push_back(HDR_BYTE0);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(HDR_BYTE0);
    byte_stream.push_back(HDR_BYTE1);
    byte_stream.push_back(8'hFF);
    byte_stream.push_back(HDR_BYTE0);
    byte_stream.push_back(HDR_BYTE0);
    byte_stream.push_back(HDR_BYTE1);
    byte_stream.push_back(HDR_BYTE2);
    byte_stream.push_back(HDR_BYTE0);
    byte_stream.push_back(HDR_BYTE1);
    byte_stream.push_back(HDR_BYTE0);
    byte_stream.push_back(HDR_BYTE1);
    byte_stream.push_back(HDR_BYTE2);

    push_frame(gain_payload(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8001, 8'hFF), 8'h00);
    push_frame(gain_payload(16'h0000, 16'h0100, 16'h00FF, 16'h0080, 16'h7F00, 8'h00), 8'hFF);
    flush_stream();

    // sender pause until the directed results are all back
    wait_results_drained();

    frame_idx = 0;
    while (bytes_sent < TARGET_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        foreach (body[i]) body[i] = pick_byte();
        push_frame(body, pick_byte());
        frame_idx++;
        if (frame_idx == 8) hold_req = 1'b1;
      end else if (kind < 85) begin
        // header cut short
        byte_stream.push_back(HDR_BYTE0);
        if ($urandom_range(0, 1) == 1) byte_stream.push_back(HDR_BYTE1);
        byte_stream.push_back(pick_byte());
      end else if (kind < 92) begin
        // frame cut short, the next header lands in its payload
        byte_stream.push_back(HDR_BYTE0);
        byte_stream.push_back(HDR_BYTE1);
        byte_stream.push_back(HDR_BYTE2);
        n = $urandom_range(1, FRAME_PAYLOAD - 1);
        repeat (n) byte_stream.push_back(pick_byte());
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) byte_stream.push_back(8'($urandom_range(0, 255)));
      end
      flush_stream();
      if (frame_idx == 20 && kind < 75) wait_results_drained();
    end

    rx_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("gain_frame_parser regression: pass");
    end else begin
      $display("gain_frame_parser regression: fail");
    end
    $finish;
  end

endmodule
